[hdl/pfifo_pkg.sv]
// ----------------------------------------------------------------------------
// pfifo_pkg
// Types, codes and sizes shared by the multi-channel pipe FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package pfifo_pkg;

	localparam int CHANNELS   = 64;
	localparam int FIFO_DEPTH = 1024;
	localparam int MAX_REFS   = 255;

	localparam int CH_W   = 6;
	localparam int FILL_W = 11;
	localparam int BYTE_W = 8;
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int REF_W  = $clog2(MAX_REFS + 1);
	localparam int SLOT_W = CH_W + PTR_W;

	localparam logic [2:0] ACT_CREATE = 3'd0;
	localparam logic [2:0] ACT_WRITE  = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_GRAB   = 3'd3;
	localparam logic [2:0] ACT_DROP   = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EOS    = 3'd1;
	localparam logic [2:0] ST_BLOCK  = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_NOFREE = 3'd4;
	localparam logic [2:0] ST_COUNT  = 3'd5;

	typedef struct packed {
		logic [2:0]        action;
		logic [CH_W-1:0]   channel;
		logic              writer_end;
		logic [BYTE_W-1:0] write_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [BYTE_W-1:0] read_byte;
		logic [CH_W-1:0]   channel_out;
		logic [FILL_W-1:0] fill_level;
		logic              wake;
		logic              destroyed;
	} rsp_t;

	typedef struct packed {
		logic [PTR_W-1:0]  head;
		logic [FILL_W-1:0] fill;
		logic [REF_W-1:0]  rrefs;
		logic [REF_W-1:0]  wrefs;
	} ctx_t;

	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] addr;
		ctx_t            data;
	} ctx_wr_t;

	typedef struct packed {
		logic              wen;
		logic              ren;
		logic [SLOT_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} byte_req_t;

endpackage

`default_nettype wire

[hdl/pfifo_ctx_mem.sv]
// ----------------------------------------------------------------------------
// pfifo_ctx_mem
// Per-channel context memory (head, fill, reference counts), registered read.
// Entries never written read as zero through reset-cleared valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_ctx_mem (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         rd_en,
	input  wire [pfifo_pkg::CH_W-1:0]   rd_addr,
	input  wire pfifo_pkg::ctx_wr_t     wr,
	output pfifo_pkg::ctx_t             rd_data
);
	import pfifo_pkg::*;

	ctx_t               mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	ctx_t               rd_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[hdl/pfifo_data_mem.sv]
// ----------------------------------------------------------------------------
// pfifo_data_mem
// Byte store for all channel FIFOs, one request (write, read or both) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_data_mem (
	input  wire                          clk,
	input  wire pfifo_pkg::byte_req_t    req,
	output logic [pfifo_pkg::BYTE_W-1:0] rd_data
);
	import pfifo_pkg::*;

	logic [BYTE_W-1:0] mem [2**SLOT_W];

	always_ff @(posedge clk) begin
		if (req.wen) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.ren) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

[hdl/pfifo_free_map.sv]
// ----------------------------------------------------------------------------
// pfifo_free_map
// Occupancy map of channels with no references and lowest-free encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_free_map (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire pfifo_pkg::ctx_wr_t     wr,
	output logic                        any_free,
	output logic [pfifo_pkg::CH_W-1:0]  free_ch
);
	import pfifo_pkg::*;

	logic [CHANNELS-1:0] free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (wr.en) begin
			free_q[wr.addr] <= (wr.data.rrefs == '0) && (wr.data.wrefs == '0);
		end
	end

	always_comb begin
		free_ch = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_ch = CH_W'(i);
			end
		end
	end

	assign any_free = |free_q;

endmodule

`default_nettype wire

[hdl/multi_channel_pipe_fifo.sv]
// ----------------------------------------------------------------------------
// multi_channel_pipe_fifo
// Table of byte FIFOs with reader/writer reference counts, one action per
// command, one result per command.
// ----------------------------------------------------------------------------
// Sequence: the start transfer registers the command and reads the context;
//   the result is registered in the look state, and a read that returns a byte
//   adds a fetch state for the byte store read. A new command is taken only
//   when idle; busy covers the context memory read and the byte store read.
// Reset: clears context valid bits and the occupancy map at once; no sweep.
// The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none

module multi_channel_pipe_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire pfifo_pkg::cmd_t cmd,
	output logic               done,
	output pfifo_pkg::rsp_t    rsp
);
	import pfifo_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_LOOK  = 3'b010,
		S_FETCH = 3'b100
	} state_t;

	localparam logic [CH_W:0]   CHANNELS_C = (CH_W + 1)'(CHANNELS);
	localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(FIFO_DEPTH);
	localparam logic [PTR_W:0]  DEPTH_P    = (PTR_W + 1)'(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_P    = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [REF_W-1:0] MAX_R     = REF_W'(MAX_REFS);
	localparam logic [REF_W-1:0] ONE_R     = REF_W'(1);

	state_t            state_q;
	cmd_t              cmd_s1;
	logic              alloc_ok_s1;
	logic [CH_W-1:0]   alloc_ch_s1;
	logic              accept;
	logic              any_free;
	logic [CH_W-1:0]   free_ch;
	ctx_t              ctx;
	ctx_wr_t           ctx_wr;
	byte_req_t         byte_req;
	logic [BYTE_W-1:0] byte_rd;
	rsp_t              rsp_nxt;
	rsp_t              rsp_q;
	logic              done_q;
	logic              fetch;
	logic [PTR_W:0]    wpos_sum;
	logic [PTR_W-1:0]  wpos;
	logic [REF_W-1:0]  cnt;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	pfifo_free_map u_free_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (ctx_wr),
		.any_free (any_free),
		.free_ch  (free_ch)
	);

	pfifo_ctx_mem u_ctx_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr ((cmd.action == ACT_CREATE) ? free_ch : cmd.channel),
		.wr      (ctx_wr),
		.rd_data (ctx)
	);

	pfifo_data_mem u_data_mem (
		.clk     (clk),
		.req     (byte_req),
		.rd_data (byte_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			alloc_ok_s1 <= any_free;
			alloc_ch_s1 <= free_ch;
		end
	end

	always_comb begin
		wpos_sum = (PTR_W + 1)'(ctx.head) + (PTR_W + 1)'(ctx.fill);
		if (wpos_sum >= DEPTH_P) begin
			wpos_sum = wpos_sum - DEPTH_P;
		end
		wpos = wpos_sum[PTR_W-1:0];
		cnt  = cmd_s1.writer_end ? ctx.wrefs : ctx.rrefs;
	end

	always_comb begin
		rsp_nxt             = '0;
		rsp_nxt.status      = ST_OK;
		rsp_nxt.channel_out = cmd_s1.channel;
		rsp_nxt.fill_level  = ctx.fill;
		ctx_wr.en           = 1'b0;
		ctx_wr.addr         = cmd_s1.channel;
		ctx_wr.data         = ctx;
		byte_req.wen        = 1'b0;
		byte_req.ren        = 1'b0;
		byte_req.addr       = {cmd_s1.channel, ctx.head};
		byte_req.wdata      = cmd_s1.write_byte;
		fetch               = 1'b0;

		if (cmd_s1.action == ACT_CREATE) begin
			rsp_nxt.fill_level  = '0;
			if (alloc_ok_s1) begin
				rsp_nxt.channel_out = alloc_ch_s1;
				ctx_wr.addr         = alloc_ch_s1;
				ctx_wr.data         = '{head: '0, fill: '0, rrefs: ONE_R, wrefs: ONE_R};
				ctx_wr.en           = 1'b1;
			end else begin
				rsp_nxt.status      = ST_NOFREE;
				rsp_nxt.channel_out = '0;
			end
		end else if ({1'b0, cmd_s1.channel} >= CHANNELS_C) begin
			rsp_nxt.status     = ST_COUNT;
			rsp_nxt.fill_level = '0;
			rsp_nxt.wake       = (cmd_s1.action == ACT_WRITE);
		end else begin
			case (cmd_s1.action)
				ACT_WRITE: begin
					rsp_nxt.wake = 1'b1;
					if (ctx.fill >= DEPTH_F) begin
						rsp_nxt.status = ST_FULL;
					end else begin
						byte_req.wen       = 1'b1;
						byte_req.addr      = {cmd_s1.channel, wpos};
						ctx_wr.data.fill   = ctx.fill + 1'b1;
						ctx_wr.en          = 1'b1;
						rsp_nxt.fill_level = ctx.fill + 1'b1;
					end
				end
				ACT_READ: begin
					if (ctx.fill == '0) begin
						rsp_nxt.status = (ctx.wrefs == '0) ? ST_EOS : ST_BLOCK;
					end else begin
						byte_req.ren       = 1'b1;
						fetch              = 1'b1;
						ctx_wr.data.head   = (ctx.head == LAST_P) ? '0 : ctx.head + 1'b1;
						ctx_wr.data.fill   = ctx.fill - 1'b1;
						ctx_wr.en          = 1'b1;
						rsp_nxt.fill_level = ctx.fill - 1'b1;
					end
				end
				ACT_GRAB: begin
					if (cnt >= MAX_R) begin
						rsp_nxt.status = ST_COUNT;
					end else begin
						ctx_wr.en = 1'b1;
						if (cmd_s1.writer_end) begin
							ctx_wr.data.wrefs = cnt + 1'b1;
						end else begin
							ctx_wr.data.rrefs = cnt + 1'b1;
						end
					end
				end
				ACT_DROP: begin
					if (cnt == '0) begin
						rsp_nxt.status = ST_COUNT;
					end else begin
						ctx_wr.en = 1'b1;
						if (cmd_s1.writer_end) begin
							ctx_wr.data.wrefs = cnt - 1'b1;
							rsp_nxt.destroyed = (cnt == ONE_R) && (ctx.rrefs == '0);
						end else begin
							ctx_wr.data.rrefs = cnt - 1'b1;
							rsp_nxt.destroyed = (cnt == ONE_R) && (ctx.wrefs == '0);
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (state_q != S_LOOK) begin
			ctx_wr.en    = 1'b0;
			byte_req.wen = 1'b0;
			byte_req.ren = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (fetch) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			rsp_q <= rsp_nxt;
		end else if (state_q == S_FETCH) begin
			rsp_q.read_byte <= byte_rd;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[hdl/pfifo_checker.sv]
// ----------------------------------------------------------------------------
// pfifo_port_props
// Port-level checks of the multi-channel pipe FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfifo_port_props (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input wire                  done,
	input wire pfifo_pkg::rsp_t rsp
);
	import pfifo_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transfer did not make the block busy");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_NOFREE) |->
			(rsp.channel_out == '0 && rsp.fill_level == '0 && !rsp.wake))
		else $error("failed create carries nonzero fields");

	a_wake_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.wake) |->
			(rsp.status == ST_OK || rsp.status == ST_FULL || rsp.status == ST_COUNT))
		else $error("wake with unexpected status");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.read_byte == '0 && !rsp.destroyed))
		else $error("read byte or destroyed on a failed action");

endmodule

bind multi_channel_pipe_fifo pfifo_port_props u_pfifo_port_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
